### design/lfsc_pkg.sv
`default_nettype none

package lfsc_pkg;

	// Widths of the configuration port.
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_BASE_SPEED   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LOST_LIMIT   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_REVERSE_MODE = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [6:0]  BASE_SPEED_RST   = 7'd0;
	localparam logic [15:0] LOST_LIMIT_RST   = 16'd100;
	localparam logic        REVERSE_MODE_RST = 1'b0;

	// Request actions.
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	// Stop codes.
	localparam logic [1:0] STOP_NONE  = 2'd0;
	localparam logic [1:0] STOP_DARK  = 2'd1;
	localparam logic [1:0] STOP_CROSS = 2'd2;

	// Combined sensor word that marks a full crossing.
	localparam logic [15:0] CROSSING_WORD = 16'hFF7F;

	// Drive clamp bounds.
	localparam logic signed [8:0] SPEED_MAX = 9'sd100;
	localparam logic signed [8:0] SPEED_MIN = 9'sd5;

	typedef struct packed {
		logic        action;
		logic [7:0]  row_pattern;
		logic [6:0]  front_pattern;
		logic [15:0] all_pattern;
	} req_t;

	typedef struct packed {
		logic              drive_valid;
		logic signed [7:0] left_drive;
		logic signed [7:0] right_drive;
		logic              motor_halt;
		logic [1:0]        stop_code;
		logic              tracking;
	} rsp_t;

	typedef struct packed {
		logic [6:0]  base_speed;
		logic [15:0] lost_limit;
		logic        reverse_mode;
	} cfg_t;

	// Result of the steering pattern lookup.
	typedef struct packed {
		logic              hit;
		logic signed [7:0] dl;
		logic signed [7:0] dr;
	} steer_t;

endpackage

`default_nettype wire

### design/lfsc_lookup.sv
`default_nettype none

module lfsc_lookup (
	input  wire logic [7:0]      row_pattern,
	input  wire logic            reverse_mode,
	output lfsc_pkg::steer_t     steer
);

	localparam int ROW_W = 8;

	logic [ROW_W-1:0] row_rev;
	logic [ROW_W-1:0] gd;

	// Driving backward mirrors the sensor row.
	always_comb begin
		for (int i = 0; i < ROW_W; i++) begin
			row_rev[i] = row_pattern[ROW_W-1-i];
		end
	end

	assign gd = reverse_mode ? row_rev : row_pattern;

	always_comb begin
		steer = '0;
		steer.hit = 1'b1;
		unique case (gd)
			8'hE7: begin
				steer.dl = 8'sd0;
				steer.dr = 8'sd0;
			end
			8'hF7, 8'hF3, 8'hFB: begin
				steer.dl = 8'sd30;
				steer.dr = -8'sd40;
			end
			8'hEF, 8'hCF: begin
				steer.dl = -8'sd40;
				steer.dr = 8'sd30;
			end
			8'hF9, 8'hFD: begin
				steer.dl = 8'sd60;
				steer.dr = -8'sd70;
			end
			8'hFC: begin
				steer.dl = 8'sd60;
				steer.dr = -8'sd90;
			end
			8'hFE: begin
				steer.dl = 8'sd80;
				steer.dr = -8'sd120;
			end
			8'h9F, 8'hDF: begin
				steer.dl = -8'sd70;
				steer.dr = 8'sd60;
			end
			8'h3F, 8'hBF: begin
				steer.dl = -8'sd90;
				steer.dr = 8'sd70;
			end
			8'h7F: begin
				steer.dl = -8'sd120;
				steer.dr = 8'sd80;
			end
			default: begin
				steer.hit = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/lfsc_step.sv
`default_nettype none

module lfsc_step (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire lfsc_pkg::req_t   req,
	input  wire lfsc_pkg::cfg_t   cfg,
	output lfsc_pkg::rsp_t        rsp
);

	logic              running_q;
	logic [15:0]       crossing_count_q;
	logic signed [8:0] left_target_q;
	logic signed [8:0] right_target_q;

	logic              running_n;
	logic [15:0]       crossing_count_n;
	logic signed [8:0] left_target_n;
	logic signed [8:0] right_target_n;

	lfsc_pkg::steer_t  steer;
	logic              drive;
	logic signed [8:0] base_s;

	function automatic logic signed [7:0] clamp_drive(input logic signed [8:0] v);
		logic signed [8:0] c;
		c = v;
		if (v >= 9'sd0) begin
			if (v > lfsc_pkg::SPEED_MAX) c = lfsc_pkg::SPEED_MAX;
			if (v < lfsc_pkg::SPEED_MIN) c = lfsc_pkg::SPEED_MIN;
		end else begin
			if (v < -lfsc_pkg::SPEED_MAX) c = -lfsc_pkg::SPEED_MAX;
			if (v > -lfsc_pkg::SPEED_MIN) c = -lfsc_pkg::SPEED_MIN;
		end
		return c[7:0];
	endfunction

	lfsc_lookup u_lookup (
		.row_pattern  (req.row_pattern),
		.reverse_mode (cfg.reverse_mode),
		.steer        (steer)
	);

	assign base_s = $signed({2'b00, cfg.base_speed});

	always_comb begin
		running_n        = running_q;
		crossing_count_n = crossing_count_q;
		left_target_n    = left_target_q;
		right_target_n   = right_target_q;
		drive            = 1'b0;
		rsp              = '0;
		if (req.action == lfsc_pkg::ACT_START) begin
			running_n = 1'b1;
		end else if (running_q) begin
			if (req.front_pattern == 7'd0) begin
				running_n     = 1'b0;
				rsp.motor_halt = 1'b1;
				rsp.stop_code  = lfsc_pkg::STOP_DARK;
			end else begin
				drive = 1'b1;
				if (steer.hit) begin
					left_target_n  = base_s + 9'(steer.dl);
					right_target_n = base_s + 9'(steer.dr);
				end else if (req.all_pattern == lfsc_pkg::CROSSING_WORD) begin
					if (crossing_count_q >= cfg.lost_limit) begin
						crossing_count_n = '0;
						running_n        = 1'b0;
						rsp.motor_halt   = 1'b1;
						rsp.stop_code    = lfsc_pkg::STOP_CROSS;
						drive            = 1'b0;
					end else begin
						crossing_count_n = crossing_count_q + 16'd1;
					end
				end else begin
					crossing_count_n = '0;
				end
			end
		end
		if (drive) begin
			rsp.drive_valid = 1'b1;
			rsp.left_drive  = clamp_drive(left_target_n);
			rsp.right_drive = clamp_drive(right_target_n);
		end
		rsp.tracking = running_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q        <= 1'b0;
			crossing_count_q <= '0;
			left_target_q    <= '0;
			right_target_q   <= '0;
		end else if (en) begin
			running_q        <= running_n;
			crossing_count_q <= crossing_count_n;
			left_target_q    <= left_target_n;
			right_target_q   <= right_target_n;
		end
	end

endmodule

`default_nettype wire

### design/line_follow_steering_controller_top.sv
// Line-follow steering controller.
//
// A request carries one sensor sample (action 0) or a start command
// (action 1). Each accepted request produces exactly one response with the
// clamped wheel speeds, the halt flag, the stop code and the tracking flag.
// Both channels use valid/ready; the configuration port is a plain write
// port (cfg_wr_en, cfg_addr, cfg_wdata) that takes effect at once and must
// only be written while no request is in flight.
//
// A request is registered on acceptance into the input register; its
// decision is then computed from the state registers and loaded into the
// response register once that register is empty or being drained.
// The block takes one request per cycle; the only limit is the response
// register, which is loaded whenever it is empty or being drained.
// When the receiver stalls, the response holds, the input register fills,
// and req_ready drops until rsp_ready returns.
// Reset clears the running flag, the crossing counter and both wheel
// targets, and loads base speed 0, crossing limit 100 and forward driving.
`default_nettype none

module line_follow_steering_controller_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire lfsc_pkg::req_t                     req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output lfsc_pkg::rsp_t                          rsp,
	input  wire logic                               cfg_wr_en,
	input  wire logic [lfsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [lfsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	// Configuration registers.
	lfsc_pkg::cfg_t cfg_q;

	// Input stage.
	logic           req_valid_s1;
	lfsc_pkg::req_t req_s1;

	// Output stage.
	logic           rsp_valid_s2;
	lfsc_pkg::rsp_t rsp_s2;

	lfsc_pkg::rsp_t rsp_next;
	logic           advance;

	// The held request moves on whenever the response slot is free or drained.
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_speed   <= lfsc_pkg::BASE_SPEED_RST;
			cfg_q.lost_limit   <= lfsc_pkg::LOST_LIMIT_RST;
			cfg_q.reverse_mode <= lfsc_pkg::REVERSE_MODE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				lfsc_pkg::REG_BASE_SPEED:   cfg_q.base_speed   <= cfg_wdata[6:0];
				lfsc_pkg::REG_LOST_LIMIT:   cfg_q.lost_limit   <= cfg_wdata[15:0];
				lfsc_pkg::REG_REVERSE_MODE: cfg_q.reverse_mode <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	lfsc_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.cfg    (cfg_q),
		.rsp    (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	// Issued speeds and a halt never appear together.
	a_drive_xor_halt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.drive_valid && rsp.motor_halt))
		else $error("drive and halt issued together");

	// Issued speeds lie inside the clamp windows.
	a_left_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.drive_valid |->
			($signed(rsp.left_drive) >= 8'sd5 && $signed(rsp.left_drive) <= 8'sd100) ||
			($signed(rsp.left_drive) <= -8'sd5 && $signed(rsp.left_drive) >= -8'sd100))
		else $error("left drive outside clamp window");

	a_right_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.drive_valid |->
			($signed(rsp.right_drive) >= 8'sd5 && $signed(rsp.right_drive) <= 8'sd100) ||
			($signed(rsp.right_drive) <= -8'sd5 && $signed(rsp.right_drive) >= -8'sd100))
		else $error("right drive outside clamp window");

	// A stop always halts the motors and ends tracking.
	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.stop_code != lfsc_pkg::STOP_NONE |->
			rsp.motor_halt && !rsp.tracking)
		else $error("stop without halt");

	// A held request that cannot move on blocks new requests.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 && rsp_valid_s2 && !rsp_ready |-> !req_ready)
		else $error("request accepted over a stalled input register");

endmodule

`default_nettype wire

### bench/line_follow_steering_controller_top_tb.sv
`default_nettype none

module line_follow_steering_controller_top_tb;

	// Clock, reset and the block's inputs. Every input starts at a known
	// value so nothing floats before the first clock edge.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	lfsc_pkg::req_t req = '0;
	logic rsp_ready = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [lfsc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [lfsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	logic req_ready;
	logic rsp_valid;
	lfsc_pkg::rsp_t rsp;

	line_follow_steering_controller_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sensor requests waiting to be offered, and the wheel commands that the
	// steering model says must come back, oldest first.
	lfsc_pkg::req_t sensor_reqs[$];
	lfsc_pkg::rsp_t wheel_cmds[$];

	// Percentages of cycles in which the sender holds back and the receiver
	// stalls. The sequencer changes them between phases.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	int mismatches = 0;
	int n_reqs = 0;
	int n_starts = 0;
	int n_drives = 0;
	int n_dark = 0;
	int n_cross = 0;

	// Our copy of the configuration registers, mirrored on every write.
	logic [6:0] base_cfg = lfsc_pkg::BASE_SPEED_RST;
	logic [15:0] limit_cfg = lfsc_pkg::LOST_LIMIT_RST;
	logic rev_cfg = lfsc_pkg::REVERSE_MODE_RST;

	// Our copy of the controller state, starting from its reset values.
	logic tracking_st = 1'b0;
	logic [15:0] cross_count = '0;
	logic signed [8:0] left_tgt = '0;
	logic signed [8:0] right_tgt = '0;

	function automatic logic [7:0] mirror_row(input logic [7:0] v);
		logic [7:0] m;
		for (int i = 0; i < 8; i++)
			m[7-i] = v[i];
		return m;
	endfunction

	// Steering table: each known row gives a left and a right offset from
	// the base speed. A low bit means the sensor sees the line.
	function automatic logic steer_offset(input logic [7:0] gd, output int dl, output int dr);
		logic hit;
		hit = 1'b1;
		dl = 0;
		dr = 0;
		case (gd)
			8'hE7: begin dl = 0; dr = 0; end
			8'hF7, 8'hF3, 8'hFB: begin dl = 30; dr = -40; end
			8'hEF, 8'hCF: begin dl = -40; dr = 30; end
			8'hF9, 8'hFD: begin dl = 60; dr = -70; end
			8'hFC: begin dl = 60; dr = -90; end
			8'hFE: begin dl = 80; dr = -120; end
			8'h9F, 8'hDF: begin dl = -70; dr = 60; end
			8'h3F, 8'hBF: begin dl = -90; dr = 70; end
			8'h7F: begin dl = -120; dr = 80; end
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// True when a raw row would hit the table under the current direction.
	function automatic logic row_hits(input logic [7:0] row);
		int dl, dr;
		return steer_offset(rev_cfg ? mirror_row(row) : row, dl, dr);
	endfunction

	// The issued speed never sits inside the dead band around zero and
	// never exceeds full speed in either direction.
	function automatic logic signed [7:0] clamp_speed(input logic signed [8:0] t);
		int v;
		v = t;
		if (v >= 0) begin
			if (v > int'(lfsc_pkg::SPEED_MAX)) v = lfsc_pkg::SPEED_MAX;
			if (v < int'(lfsc_pkg::SPEED_MIN)) v = lfsc_pkg::SPEED_MIN;
		end else begin
			if (v < -int'(lfsc_pkg::SPEED_MAX)) v = -int'(lfsc_pkg::SPEED_MAX);
			if (v > -int'(lfsc_pkg::SPEED_MIN)) v = -int'(lfsc_pkg::SPEED_MIN);
		end
		return 8'(v);
	endfunction

	// Advances our copy of the controller by one request and returns the
	// wheel command that the block must answer with.
	function automatic lfsc_pkg::rsp_t steer_predict(input lfsc_pkg::req_t r);
		lfsc_pkg::rsp_t o;
		logic [7:0] gd;
		int dl, dr;
		logic drive;
		o = '0;
		if (r.action == lfsc_pkg::ACT_START) begin
			tracking_st = 1'b1;
		end else if (tracking_st) begin
			if (r.front_pattern == '0) begin
				// Every front sensor is dark: the line is gone.
				tracking_st = 1'b0;
				o.motor_halt = 1'b1;
				o.stop_code = lfsc_pkg::STOP_DARK;
			end else begin
				gd = rev_cfg ? mirror_row(r.row_pattern) : r.row_pattern;
				drive = 1'b1;
				if (steer_offset(gd, dl, dr)) begin
					left_tgt = 9'(int'(base_cfg) + dl);
					right_tgt = 9'(int'(base_cfg) + dr);
				end else if (r.all_pattern == lfsc_pkg::CROSSING_WORD) begin
					// Sitting on a crossing: tolerated up to the limit, then stop.
					if (cross_count >= limit_cfg) begin
						cross_count = '0;
						tracking_st = 1'b0;
						o.motor_halt = 1'b1;
						o.stop_code = lfsc_pkg::STOP_CROSS;
						drive = 1'b0;
					end else begin
						cross_count = cross_count + 16'd1;
					end
				end else begin
					cross_count = '0;
				end
				if (drive) begin
					o.drive_valid = 1'b1;
					o.left_drive = clamp_speed(left_tgt);
					o.right_drive = clamp_speed(right_tgt);
				end
			end
		end
		o.tracking = tracking_st;
		return o;
	endfunction

	// Driver: offers the next pending request whenever the channel is free,
	// holding back at random. A request is predicted at the very edge that
	// accepts it, so the prediction sees the state in force at that moment.
	always @(posedge clk) begin
		lfsc_pkg::rsp_t cmd;
		logic taken;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			taken = req_valid && req_ready;
			if (taken) begin
				cmd = steer_predict(req);
				wheel_cmds.push_back(cmd);
				n_reqs++;
				if (req.action == lfsc_pkg::ACT_START) n_starts++;
				if (cmd.drive_valid) n_drives++;
				if (cmd.stop_code == lfsc_pkg::STOP_DARK) n_dark++;
				if (cmd.stop_code == lfsc_pkg::STOP_CROSS) n_cross++;
			end
			// Valid stays up with the same request until it is taken.
			if (!req_valid || taken) begin
				if (sensor_reqs.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					req <= sensor_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string fname, input logic signed [31:0] want_v,
			input logic signed [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
			mismatches++;
		end
	endtask

	// Monitor: takes responses with a randomly stalling ready and compares
	// each one, field by field, with the oldest predicted wheel command.
	always @(posedge clk) begin
		lfsc_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (wheel_cmds.size() == 0) begin
					$display("%0t: response %h arrived with no request outstanding, expected none",
						$time, rsp);
					mismatches++;
				end else begin
					want = wheel_cmds.pop_front();
					check_field("drive_valid", want.drive_valid, rsp.drive_valid);
					check_field("left_drive", $signed(want.left_drive), $signed(rsp.left_drive));
					check_field("right_drive", $signed(want.right_drive), $signed(rsp.right_drive));
					check_field("motor_halt", want.motor_halt, rsp.motor_halt);
					check_field("stop_code", want.stop_code, rsp.stop_code);
					check_field("tracking", want.tracking, rsp.tracking);
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Writes one configuration register and mirrors it into our copy once
	// the block has taken it.
	task automatic write_reg(input logic [lfsc_pkg::CFG_ADDR_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[lfsc_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			lfsc_pkg::REG_BASE_SPEED: base_cfg = 7'(val);
			lfsc_pkg::REG_LOST_LIMIT: limit_cfg = 16'(val);
			lfsc_pkg::REG_REVERSE_MODE: rev_cfg = 1'(val);
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic configure(input int base, input int limit, input int rev);
		write_reg(lfsc_pkg::REG_BASE_SPEED, base);
		write_reg(lfsc_pkg::REG_LOST_LIMIT, limit);
		write_reg(lfsc_pkg::REG_REVERSE_MODE, rev);
	endtask

	task automatic push_req(input logic act, input logic [7:0] row, input logic [6:0] front,
			input logic [15:0] all);
		lfsc_pkg::req_t r;
		r.action = act;
		r.row_pattern = row;
		r.front_pattern = front;
		r.all_pattern = all;
		sensor_reqs.push_back(r);
	endtask

	// Waits until every request has been taken and answered, then lets the
	// pipeline run dry before anything else is touched.
	task automatic settle();
		while (sensor_reqs.size() != 0 || req_valid || wheel_cmds.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// Random traffic shaped like real driving: mostly ticks whose row hits
	// the steering table, some start commands, occasional loss of the line,
	// and bursts of crossing samples long enough to run into a small limit.
	task automatic queue_traffic(input int count);
		int pushed, roll, lim, len;
		logic [7:0] row;
		pushed = 0;
		lim = (limit_cfg < 6) ? int'(limit_cfg) : 6;
		while (pushed < count) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				len = $urandom_range(lim + 2, 1);
				repeat (len) begin
					do row = 8'($urandom_range(255)); while (row_hits(row));
					push_req(lfsc_pkg::ACT_TICK, row, 7'($urandom_range(127, 1)),
						lfsc_pkg::CROSSING_WORD);
					pushed++;
				end
			end else if (roll < 20) begin
				push_req(lfsc_pkg::ACT_START, 8'($urandom_range(255)),
					7'($urandom_range(127)), 16'($urandom_range(65535)));
				pushed++;
			end else begin
				if ($urandom_range(99) < 60) begin
					do row = 8'($urandom_range(255)); while (!row_hits(row));
				end else begin
					row = 8'($urandom_range(255));
				end
				push_req(lfsc_pkg::ACT_TICK, row,
					($urandom_range(99) < 5) ? 7'd0 : 7'($urandom_range(127, 1)),
					($urandom_range(99) < 25) ? lfsc_pkg::CROSSING_WORD :
						16'($urandom_range(65535)));
				pushed++;
			end
		end
	endtask

	task automatic run_phase(input int base, input int limit, input int rev,
			input int gap_pct, input int stall_pct, input int count);
		configure(base, limit, rev);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		queue_traffic(count);
		settle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pass at base speed zero, forward, crossing limit two. Zero
		// base shows the dead band on the straight row and the negative clamp
		// on the hard turns.
		configure(0, 2, 0);
		push_req(lfsc_pkg::ACT_TICK, 8'hE7, 7'h7F, 16'h0000);   // tick before start is ignored
		push_req(lfsc_pkg::ACT_START, 8'h00, 7'h00, 16'hFFFF);
		push_req(lfsc_pkg::ACT_TICK, 8'hE7, 7'h7F, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hF7, 7'h01, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hEF, 7'h02, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hF3, 7'h04, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hFB, 7'h08, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hF9, 7'h10, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hFD, 7'h20, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hFC, 7'h40, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hFE, 7'h7F, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hCF, 7'h7F, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'h9F, 7'h7F, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hDF, 7'h7F, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'h3F, 7'h7F, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'hBF, 7'h7F, 16'h0000);
		push_req(lfsc_pkg::ACT_TICK, 8'h7F, 7'h7F, 16'h0000);
		// An unknown row off any crossing keeps the last targets.
		push_req(lfsc_pkg::ACT_TICK, 8'h00, 7'h01, 16'h1234);
		// Three crossing samples: two are tolerated, the third stops.
		push_req(lfsc_pkg::ACT_TICK, 8'hFF, 7'h40, lfsc_pkg::CROSSING_WORD);
		push_req(lfsc_pkg::ACT_TICK, 8'hFF, 7'h40, lfsc_pkg::CROSSING_WORD);
		push_req(lfsc_pkg::ACT_TICK, 8'hFF, 7'h40, lfsc_pkg::CROSSING_WORD);
		push_req(lfsc_pkg::ACT_TICK, 8'hE7, 7'h7F, 16'h0000);   // stopped again, ignored
		push_req(lfsc_pkg::ACT_START, 8'hFF, 7'h7F, 16'h0000);
		// All front sensors dark.
		push_req(lfsc_pkg::ACT_TICK, 8'hE7, 7'h00, lfsc_pkg::CROSSING_WORD);
		settle();

		// Random phases over the register extremes and the idling patterns.
		run_phase(127, 65535, 0, 0, 0, 125);
		run_phase(100, 0, 1, 58, 0, 125);
		run_phase(0, 3, 0, 0, 58, 125);
		run_phase($urandom_range(127), $urandom_range(8), 1, 32, 32, 125);
		run_phase($urandom_range(100), 1, 0, 0, 0, 125);

		$display("Ran %0d requests over six register settings: %0d starts, %0d speed commands,",
			n_reqs, n_starts, n_drives);
		$display("%0d stops on lost line and %0d stops on a long crossing; %0d mismatches.",
			n_dark, n_cross, mismatches);
		if (mismatches == 0) begin
			$display("line_follow_steering_controller_top test passed");
		end else begin
			$display("line_follow_steering_controller_top test failed");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run of all phases.
	initial begin
		#400000;
		$display("Timed out with %0d requests pending and %0d responses outstanding.",
			sensor_reqs.size(), wheel_cmds.size());
		$display("line_follow_steering_controller_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
